@@ hdl/nsr_pkg.sv @@
// Shared types, widths and constants for the Newton-Raphson square root block.
package nsr_pkg;

    localparam int NSR_FRAC_BITS = 16;
    localparam int DATA_W        = 32;
    localparam int WIDE_W        = 2 * DATA_W;
    localparam int ITER_W        = 8;
    localparam int THR_W         = 16;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 1;
    localparam int DIV_CNT_W     = $clog2(WIDE_W);

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITERATIONS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_THRESHOLD = 1'b1;

    localparam logic [ITER_W-1:0] MAX_ITER_RESET = 8'd100;
    localparam logic [THR_W-1:0]  THRESH_RESET   = 16'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUB,
        ST_DIV,
        ST_UPD,
        ST_FINISH
    } nsr_state_t;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic div_start;
        logic upd;
        logic load_out;
    } nsr_cmd_t;

    typedef struct packed {
        logic skip;
        logic div_done;
        logic stop;
    } nsr_status_t;

endpackage

@@ hdl/nsr_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
module nsr_div
    import nsr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WIDE_W-1:0] dividend,
    input  logic [DATA_W:0]   divisor,
    output logic              done,
    output logic [WIDE_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDE_W-1:0]    quo_reg, quo_next;
    logic [DATA_W:0]      rem_reg, rem_next;
    logic [DATA_W:0]      den_reg, den_next;
    logic [DATA_W+1:0]    trial;
    logic [DATA_W+1:0]    trial_diff;

    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(WIDE_W - 1);

    assign trial      = {rem_reg, quo_reg[WIDE_W-1]};
    assign trial_diff = trial - {1'b0, den_reg};
    assign done       = busy_reg && (cnt_reg == CNT_LAST);
    assign quotient   = quo_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (done)
            begin
                busy_next = 1'b0;
            end
            if (!trial_diff[DATA_W+1])
            begin
                rem_next = trial_diff[DATA_W:0];
                quo_next = {quo_reg[WIDE_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DATA_W:0];
                quo_next = {quo_reg[WIDE_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

endmodule

@@ hdl/nsr_datapath.sv @@
// Datapath: configuration registers, estimate, squaring, division and update.
module nsr_datapath
    import nsr_pkg::*;
#(
    parameter int FRAC_BITS = NSR_FRAC_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [DATA_W-1:0]    radicand,
    input  logic [DATA_W-1:0]    initial_guess,
    input  nsr_cmd_t             cmd,
    output nsr_status_t          status,
    output logic [DATA_W-1:0]    root,
    output logic [ITER_W-1:0]    iterations_used,
    output logic                 converged,
    output logic                 divide_by_zero
);

    logic [ITER_W-1:0] max_iter_reg;
    logic [THR_W-1:0]  thr_reg;
    logic [DATA_W-1:0] a_reg;
    logic [DATA_W-1:0] x_reg, x_next;
    logic [WIDE_W-1:0] xx_reg;
    logic              ge_reg;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              conv_reg, conv_next;
    logic              dz_reg;
    logic [DATA_W-1:0] root_reg;
    logic [ITER_W-1:0] iters_out_reg;
    logic              conv_out_reg;
    logic              dz_out_reg;

    logic [WIDE_W-1:0] big_a;
    logic              xx_ge;
    logic [WIDE_W-1:0] diff;
    logic              div_done;
    logic [WIDE_W-1:0] quo;
    logic [DATA_W-1:0] q_low;
    logic [DATA_W:0]   sum;
    logic              sat;
    logic [DATA_W-1:0] step;

    assign big_a = WIDE_W'(a_reg) << FRAC_BITS;
    assign xx_ge = xx_reg >= big_a;
    assign diff  = xx_ge ? (xx_reg - big_a) : (big_a - xx_reg);

    nsr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (diff),
        .divisor  ({x_reg, 1'b0}),
        .done     (div_done),
        .quotient (quo)
    );

    assign q_low = quo[DATA_W-1:0];
    assign sum   = {1'b0, x_reg} + {1'b0, q_low};
    assign sat   = (|quo[WIDE_W-1:DATA_W]) || sum[DATA_W];

    always_comb
    begin
        if (ge_reg)
        begin
            x_next = x_reg - q_low;
            step   = q_low;
        end
        else if (sat)
        begin
            x_next = '1;
            step   = ~x_reg;
        end
        else
        begin
            x_next = sum[DATA_W-1:0];
            step   = q_low;
        end
        conv_next = step < DATA_W'(thr_reg);
        iter_next = iter_reg + 1'b1;
    end

    assign status.skip     = (initial_guess == '0) || (max_iter_reg == '0);
    assign status.div_done = div_done;
    assign status.stop     = conv_next || (iter_next == max_iter_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= MAX_ITER_RESET;
            thr_reg      <= THRESH_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MAX_ITERATIONS: max_iter_reg <= cfg_data[ITER_W-1:0];
                CFG_STEP_THRESHOLD: thr_reg      <= cfg_data[THR_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            a_reg    <= radicand;
            x_reg    <= initial_guess;
            iter_reg <= '0;
            conv_reg <= 1'b0;
            dz_reg   <= (initial_guess == '0);
        end
        if (cmd.mul)
        begin
            xx_reg <= WIDE_W'(x_reg) * WIDE_W'(x_reg);
        end
        if (cmd.div_start)
        begin
            ge_reg <= xx_ge;
        end
        if (cmd.upd)
        begin
            x_reg    <= x_next;
            iter_reg <= iter_next;
            conv_reg <= conv_next;
        end
        if (cmd.load_out)
        begin
            root_reg      <= x_reg;
            iters_out_reg <= iter_reg;
            conv_out_reg  <= conv_reg;
            dz_out_reg    <= dz_reg;
        end
    end

    assign root            = root_reg;
    assign iterations_used = iters_out_reg;
    assign converged       = conv_out_reg;
    assign divide_by_zero  = dz_out_reg;

endmodule

@@ hdl/nsr_ctrl.sv @@
// Controller state machine sequencing the Newton steps and the result handshake.
module nsr_ctrl
    import nsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    output logic        res_valid,
    input  logic        res_stall,
    input  nsr_status_t status,
    output nsr_cmd_t    cmd
);

    nsr_state_t state_reg, state_next;
    logic       res_valid_reg, res_valid_next;
    logic       req_accept;
    logic       slot_free;

    assign req_accept = req_valid && (state_reg == ST_IDLE);
    assign slot_free  = !res_valid_reg || !res_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = status.skip ? ST_FINISH : ST_MUL;
                end
            end
            ST_MUL:    state_next = ST_SUB;
            ST_SUB:    state_next = ST_DIV;
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:    state_next = status.stop ? ST_FINISH : ST_MUL;
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        req_stall      = 1'b1;
        res_valid_next = res_valid_reg && res_stall;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall   = 1'b0;
                cmd.load_in = req_accept;
            end
            ST_MUL:    cmd.mul       = 1'b1;
            ST_SUB:    cmd.div_start = 1'b1;
            ST_DIV:    ;
            ST_UPD:    cmd.upd       = 1'b1;
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.load_out   = 1'b1;
                    res_valid_next = 1'b1;
                end
            end
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;

`ifndef ASSERT_OFF
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> state_reg != ST_IDLE)
        else $error("accepted transaction did not start work");

    a_finish_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINISH && slot_free |=> state_reg == ST_IDLE && res_valid_reg)
        else $error("finished transaction was not presented");

    a_continue_loops: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UPD && !status.stop |=> state_reg == ST_MUL)
        else $error("iteration did not continue");

    a_stall_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV && !status.div_done |=> state_reg == ST_DIV)
        else $error("left division before quotient was ready");
`endif

endmodule

@@ hdl/newton_square_root.sv @@
// Top level of the Newton-Raphson square root block.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_stall  | radicand, initial_guess
//  res     | out       | res_valid / res_stall  | root, iterations_used, converged,
//          |           |                        | divide_by_zero
//  cfg     | in        | cfg_write              | cfg_index, cfg_data
//
// Each Newton step runs square, subtract, the bit-serial divider and then the update.
// A transaction runs at most max_iterations steps; a zero guess or a zero limit
// skips the steps and goes straight to the final state.
// A new transaction is accepted only when the previous one has been placed in the
// result register; a stalled result holds the block in its final state until taken.
// Reset is asynchronous and active low and restores the register defaults.
module newton_square_root
    import nsr_pkg::*;
#(
    parameter int FRAC_BITS = NSR_FRAC_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  logic [DATA_W-1:0]    radicand,
    input  logic [DATA_W-1:0]    initial_guess,
    output logic                 res_valid,
    input  logic                 res_stall,
    output logic [DATA_W-1:0]    root,
    output logic [ITER_W-1:0]    iterations_used,
    output logic                 converged,
    output logic                 divide_by_zero
);

    nsr_cmd_t    cmd;
    nsr_status_t status;

    nsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .status    (status),
        .cmd       (cmd)
    );

    nsr_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .radicand        (radicand),
        .initial_guess   (initial_guess),
        .cmd             (cmd),
        .status          (status),
        .root            (root),
        .iterations_used (iterations_used),
        .converged       (converged),
        .divide_by_zero  (divide_by_zero)
    );

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the Newton-Raphson square root block.
module tb_top;
    import nsr_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] radicand;
        logic [DATA_W-1:0] guess;
    } sqrt_request_t;

    typedef struct packed {
        logic [DATA_W-1:0] root;
        logic [ITER_W-1:0] iterations;
        logic              converged;
        logic              divide_by_zero;
    } root_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_MAX_ITERATIONS;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    logic [DATA_W-1:0]    radicand = '0;
    logic [DATA_W-1:0]    initial_guess = '0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    logic [DATA_W-1:0]    root;
    logic [ITER_W-1:0]    iterations_used;
    logic                 converged;
    logic                 divide_by_zero;

    sqrt_request_t pending_requests[$];
    root_result_t  expected_roots[$];

    logic [ITER_W-1:0] iteration_limit = MAX_ITER_RESET;
    logic [THR_W-1:0]  step_floor = THRESH_RESET;

    int unsigned cycle_count = 0;
    int          fail_count = 0;
    int          results_taken = 0;
    int          send_gap = 0;
    int          stall_left = 0;
    int          next_long_hold = 300;
    int          stall_len;
    root_result_t  observed;
    root_result_t  wanted;
    sqrt_request_t next_request;

    newton_square_root DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .radicand        (radicand),
        .initial_guess   (initial_guess),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .root            (root),
        .iterations_used (iterations_used),
        .converged       (converged),
        .divide_by_zero  (divide_by_zero)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic root_result_t predict_root(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] guess);
        root_result_t res;
        logic [WIDE_W-1:0] est;
        logic [WIDE_W-1:0] shifted_a;
        logic [WIDE_W-1:0] square;
        logic [WIDE_W-1:0] nxt;
        logic [WIDE_W-1:0] step;
        int n;
        res = '0;
        est = {{DATA_W{1'b0}}, guess};
        n = 0;
        if (guess == '0)
        begin
            res.divide_by_zero = 1'b1;
        end
        else
        begin
            shifted_a = {{DATA_W{1'b0}}, a} << NSR_FRAC_BITS;
            while (n < int'(iteration_limit) && !res.converged)
            begin
                n++;
                square = est * est;
                if (square >= shifted_a)
                begin
                    nxt = est - (square - shifted_a) / (est << 1);
                end
                else
                begin
                    nxt = est + (shifted_a - square) / (est << 1);
                    if (nxt > 64'hFFFF_FFFF)
                        nxt = 64'hFFFF_FFFF;
                end
                step = (nxt >= est) ? nxt - est : est - nxt;
                est = nxt;
                if (step < {48'b0, step_floor})
                    res.converged = 1'b1;
            end
        end
        res.root = est[DATA_W-1:0];
        res.iterations = n[ITER_W-1:0];
        return res;
    endfunction

    // Quiet windows, where bits 11:10 of the cycle count are zero, carry no idling on either side.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (cycle_count[11:10] == 2'd0)
            return 0;
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 20);
        return $urandom_range(30, 150);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            radicand <= '0;
            initial_guess <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
                expected_roots.push_back(predict_root(radicand, initial_guess));
            if (!req_valid || !req_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_valid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    next_request = pending_requests.pop_front();
                    radicand <= next_request.radicand;
                    initial_guess <= next_request.guess;
                    req_valid <= 1'b1;
                    send_gap = pick_gap();
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(input string what, input root_result_t got,
                                   input root_result_t want);
        fail_count++;
        if (fail_count <= 10)
        begin
            $write("%s at result %0d: expected root %h iter %0d conv %0b dz %0b, ",
                   what, results_taken, want.root, want.iterations, want.converged,
                   want.divide_by_zero);
            $display("got root %h iter %0d conv %0b dz %0b",
                     got.root, got.iterations, got.converged, got.divide_by_zero);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                results_taken++;
                observed = '{root, iterations_used, converged, divide_by_zero};
                if (expected_roots.size() == 0)
                begin
                    report_mismatch("Unexpected result", observed, '0);
                end
                else
                begin
                    wanted = expected_roots.pop_front();
                    if (observed.root !== wanted.root
                        || observed.iterations !== wanted.iterations
                        || observed.converged !== wanted.converged
                        || observed.divide_by_zero !== wanted.divide_by_zero)
                        report_mismatch("Mismatch", observed, wanted);
                end
            end
            if (results_taken >= next_long_hold)
            begin
                stall_left = 3000;
                next_long_hold += 700;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                res_stall <= 1'b1;
            end
            else
            begin
                stall_len = pick_gap();
                res_stall <= (stall_len > 0);
                stall_left = (stall_len > 0) ? stall_len - 1 : 0;
            end
        end
    end

    task automatic add_request(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] g);
        pending_requests.push_back('{a, g});
    endtask

    task automatic wait_until_drained();
        @(negedge clk);
        while (pending_requests.size() != 0 || req_valid || expected_roots.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_MAX_ITERATIONS)
            iteration_limit = value[ITER_W-1:0];
        else
            step_floor = value;
    endtask

    // The upper byte of the limit write is junk that the block must ignore.
    task automatic configure(input logic [ITER_W-1:0] limit, input logic [THR_W-1:0] thresh);
        wait_until_drained();
        repeat (4) @(posedge clk);
        write_register(CFG_MAX_ITERATIONS, {8'($urandom), limit});
        write_register(CFG_STEP_THRESHOLD, thresh);
    endtask

    task automatic add_random_request();
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] g;
        logic [DATA_W-1:0] delta;
        logic [WIDE_W-1:0] square;
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 5)
        begin
            a = $urandom;
            g = '0;
        end
        else if (kind < 30)
        begin
            a = $urandom >> $urandom_range(0, 31);
            g = $urandom >> $urandom_range(0, 31);
        end
        else if (kind < 35)
        begin
            case ($urandom_range(0, 3))
                0: a = '0;
                1: a = 32'd1;
                2: a = 32'hFFFF_FFFF;
                default: a = $urandom;
            endcase
            case ($urandom_range(0, 3))
                0: g = 32'd1;
                1: g = 32'hFFFF_FFFF;
                2: g = 32'h0001_0000;
                default: g = $urandom;
            endcase
        end
        else
        begin
            g = $urandom_range(1, 32'h00FF_FFFF) >> $urandom_range(0, 20);
            if (g == '0)
                g = 32'd1;
            square = ({32'b0, g} * {32'b0, g}) >> NSR_FRAC_BITS;
            a = square[DATA_W-1:0] ^ $urandom_range(0, 15);
            delta = $urandom_range(0, g >> 2);
            g = $urandom_range(0, 1) ? g + delta : g - delta;
        end
        add_request(a, g);
    endtask

    task automatic add_random_requests(input int count);
        repeat (count) add_random_request();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        add_request(32'h0000_0000, 32'h0000_0000);
        add_request(32'hFFFF_FFFF, 32'h0000_0000);
        add_request(32'h0004_0000, 32'h0001_0000);
        add_request(32'h0004_0000, 32'h0004_0000);
        add_request(32'h0009_0000, 32'h0003_0000);
        add_request(32'h0001_0000, 32'h0001_0000);
        add_request(32'h0000_0000, 32'h0000_0001);
        add_request(32'h0000_0000, 32'hFFFF_FFFF);
        add_request(32'hFFFF_FFFF, 32'h0000_0001);
        add_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_request(32'h0000_0001, 32'h0000_0001);
        add_request(32'h1234_5678, 32'h0080_0000);

        configure(8'd0, 16'd0);
        add_request(32'h0004_0000, 32'h0001_0000);
        add_request(32'h0000_0000, 32'h0000_0000);
        add_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);

        configure(8'd255, 16'hFFFF);
        add_request(32'hFFFF_FFFF, 32'h0000_0001);
        add_request(32'h0002_0000, 32'h0001_0000);
        add_request(32'h0000_0000, 32'hFFFF_FFFF);

        configure(8'd3, 16'd0);
        add_request(32'h0004_0000, 32'h0001_0000);
        add_request(32'hFFFF_FFFF, 32'h0000_0001);
        add_request(32'h0000_0000, 32'h0000_0000);

        configure(8'd100, 16'd7);
        add_random_requests(175);
        configure(8'd255, 16'hFFFF);
        add_random_requests(175);
        configure(8'($urandom_range(0, 12)), 16'd0);
        add_random_requests(175);
        configure(8'd0, 16'($urandom));
        add_random_requests(175);
        configure(8'($urandom_range(1, 40)), 16'($urandom_range(0, 255)));
        add_random_requests(175);
        configure(8'd255, 16'd1);
        add_random_requests(175);
        configure(8'($urandom_range(0, 255)), 16'($urandom_range(1, 65535)));
        add_random_requests(175);
        configure(8'($urandom_range(1, 8)), 16'($urandom));
        add_random_requests(175);

        wait_until_drained();
        repeat (2000) @(posedge clk);
        if (fail_count == 0 && expected_roots.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #500_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/nsr_pkg.sv
hdl/nsr_div.sv
hdl/nsr_datapath.sv
hdl/nsr_ctrl.sv
hdl/newton_square_root.sv
test/tb_top.sv
